// ===== hw/rtl/pwws_pkg.sv =====
package pwws_pkg;

	localparam int COORD_BITS_DEF     = 16;
	localparam int POTENTIAL_BITS_DEF = 16;

	localparam int ROW_BITS       = 48;
	localparam int CLASS_BITS     = 18;
	localparam int FRAC_BITS      = 16;
	localparam int COL_BITS       = 16;
	localparam int ACTION_BITS    = 2;
	localparam int DIR_BITS       = 4;
	localparam int OUT_COORD_BITS = 16;
	localparam int THR_BITS       = 4;
	localparam int HEIGHT_BITS    = 16;
	localparam int NUM_NEIGH      = 9;
	localparam int CENTRE_IDX     = 4;
	localparam int COUNT_BITS     = 4;

	localparam int S_TDATA_BITS = 200;
	localparam int M_TDATA_BITS = 40;
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 3;

	typedef logic [ACTION_BITS-1:0] action_t;
	localparam action_t ACT_START  = 2'd0;
	localparam action_t ACT_MOVE   = 2'd1;
	localparam action_t ACT_SETTLE = 2'd2;

	typedef logic [1:0] class_t;
	localparam class_t CLS_EMPTY   = 2'd0;
	localparam class_t CLS_CLUSTER = 2'd1;

	typedef logic [DIR_BITS-1:0] dir_t;
	localparam dir_t DIR_STAY = 4'd4;

	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_HEIGHT    = 1'b1;

	localparam logic [THR_BITS-1:0]    THRESHOLD_RST = 4'd1;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST    = 16'd256;

	// column offset plus one of a neighbor index (index mod 3)
	function automatic logic [1:0] dir_col(input dir_t d);
		logic [1:0] c;
		case (d)
			4'd0, 4'd3, 4'd6: c = 2'd0;
			4'd2, 4'd5, 4'd8: c = 2'd2;
			default:          c = 2'd1;
		endcase
		return c;
	endfunction

	// row offset plus one of a neighbor index (index div 3)
	function automatic logic [1:0] dir_row(input dir_t d);
		logic [1:0] r;
		case (d)
			4'd0, 4'd1, 4'd2: r = 2'd0;
			4'd6, 4'd7, 4'd8: r = 2'd2;
			default:          r = 2'd1;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/potential_weighted_walk_step_unit.sv =====
// Potential-weighted walk step unit.
// Keeps one walker (column, row, finished flag) and takes one request per
// item on the slave stream: tuser carries the action (start, move, settle),
// tdata the three potential rows, the nine class codes, a random fraction
// and the spawn column. Every request gives exactly one result on the
// master stream: position after the request, chosen direction, joined and
// finished flags.
// The input register loads at the accepting edge, then the weight and
// prefix-sum register, then the result register that drives master tvalid.
// A new request can be taken every cycle as long as the pipeline does not
// stall; the roulette multiply and the walker update sit in the last stage,
// so back-to-back moves see each other's position.
// Stalls: when the receiver drops m_tready the result register holds; a
// stage only advances into a free or draining stage, so s_tready falls once
// all three stages are full.
// Reset (arst_n low) clears the walker to column 0, row 0, not finished,
// empties the pipeline and loads cluster_threshold=1, field_height=256.
// APB registers: 0x0 cluster_threshold, 0x4 field_height; write them only
// while no request is in flight.
module potential_weighted_walk_step_unit #(
	parameter int COORD_BITS     = pwws_pkg::COORD_BITS_DEF,
	parameter int POTENTIAL_BITS = pwws_pkg::POTENTIAL_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// [47:0] potentials_top, [95:48] potentials_middle, [143:96] potentials_bottom,
	// [161:144] cell_classes, [177:162] random_fraction, [193:178] start_column
	input  logic [pwws_pkg::S_TDATA_BITS-1:0]      s_tdata,
	// [1:0] action
	input  logic [pwws_pkg::ACTION_BITS-1:0]       s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// [15:0] pos_x, [31:16] pos_y, [35:32] direction, [36] joined, [37] finished
	output logic [pwws_pkg::M_TDATA_BITS-1:0]      m_tdata,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [pwws_pkg::APB_ADDR_BITS-1:0]     paddr,
	input  logic [pwws_pkg::APB_DATA_BITS-1:0]     pwdata,
	output logic [pwws_pkg::APB_DATA_BITS-1:0]     prdata,
	output logic                                   pready
);

	localparam int PB        = POTENTIAL_BITS;
	localparam int LROW      = 3 * PB;
	localparam int SUM_BITS  = PB + 3;
	localparam int LHS_BITS  = pwws_pkg::FRAC_BITS + SUM_BITS;
	localparam int NN        = pwws_pkg::NUM_NEIGH;

	// ---------------- configuration registers ----------------
	logic [pwws_pkg::THR_BITS-1:0]    threshold_q;
	logic [pwws_pkg::HEIGHT_BITS-1:0] height_q;
	logic                             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= pwws_pkg::THRESHOLD_RST;
			height_q    <= pwws_pkg::HEIGHT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				pwws_pkg::REG_THRESHOLD: threshold_q <= pwdata[pwws_pkg::THR_BITS-1:0];
				pwws_pkg::REG_HEIGHT:    height_q    <= pwdata[pwws_pkg::HEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			pwws_pkg::REG_THRESHOLD:
				prdata = pwws_pkg::APB_DATA_BITS'(threshold_q);
			pwws_pkg::REG_HEIGHT:
				prdata = pwws_pkg::APB_DATA_BITS'(height_q);
			default:
				prdata = '0;
		endcase
	end

	// ---------------- stage handshake ----------------
	logic v_s1, v_s2, m_tvalid_q;
	logic rdy_s1, rdy_s2, rdy_out;
	logic load_s1, load_s2, load_out;

	// each stage takes a request when it is empty or draining this cycle
	assign rdy_out  = !m_tvalid_q || m_tready;
	assign rdy_s2   = !v_s2 || rdy_out;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	assign load_s1  = s_tvalid && rdy_s1;
	assign load_s2  = v_s1 && rdy_s2;
	assign load_out = v_s2 && rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1       <= s_tvalid;
			if (rdy_s2)  v_s2       <= v_s1;
			if (rdy_out) m_tvalid_q <= v_s2;
		end
	end

	assign m_tvalid = m_tvalid_q;

	// ---------------- stage 1: input register ----------------
	pwws_pkg::action_t                   act_s1;
	logic [pwws_pkg::ROW_BITS-1:0]       top_s1, mid_s1, bot_s1;
	logic [pwws_pkg::CLASS_BITS-1:0]     classes_s1;
	logic [pwws_pkg::FRAC_BITS-1:0]      rnd_s1;
	logic [pwws_pkg::COL_BITS-1:0]       col_s1;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			act_s1     <= s_tuser;
			top_s1     <= s_tdata[47:0];
			mid_s1     <= s_tdata[95:48];
			bot_s1     <= s_tdata[143:96];
			classes_s1 <= s_tdata[161:144];
			rnd_s1     <= s_tdata[177:162];
			col_s1     <= s_tdata[193:178];
		end
	end

	// ---------------- stage 2: weights and running sums ----------------
	logic [LROW-1:0]               top_x, mid_x, bot_x;
	logic [PB-1:0]                 pot   [NN];
	logic [PB-1:0]                 wgt   [NN];
	logic [SUM_BITS-1:0]           cum   [NN];
	logic [NN-1:0]                 cand;
	logic [pwws_pkg::COUNT_BITS-1:0] clus_cnt;

	// lanes past the 48 row bits read as zero
	assign top_x = LROW'(top_s1);
	assign mid_x = LROW'(mid_s1);
	assign bot_x = LROW'(bot_s1);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pot[k]     = top_x[k*PB +: PB];
			pot[3 + k] = mid_x[k*PB +: PB];
			pot[6 + k] = bot_x[k*PB +: PB];
		end
		clus_cnt = '0;
		for (int i = 0; i < NN; i++) begin
			cand[i] = (i != pwws_pkg::CENTRE_IDX) &&
			          (classes_s1[2*i +: 2] == pwws_pkg::CLS_EMPTY);
			// distance to the centre potential
			wgt[i] = (pot[i] >= pot[pwws_pkg::CENTRE_IDX]) ?
			         pot[i] - pot[pwws_pkg::CENTRE_IDX] :
			         pot[pwws_pkg::CENTRE_IDX] - pot[i];
			if (classes_s1[2*i +: 2] == pwws_pkg::CLS_CLUSTER)
				clus_cnt = clus_cnt + pwws_pkg::COUNT_BITS'(1);
		end
		// cumulative weight over candidates, index order
		cum[0] = cand[0] ? SUM_BITS'(wgt[0]) : '0;
		for (int i = 1; i < NN; i++)
			cum[i] = cum[i-1] + (cand[i] ? SUM_BITS'(wgt[i]) : SUM_BITS'(0));
	end

	pwws_pkg::action_t                act_s2;
	logic [NN-1:0]                    cand_s2;
	logic [SUM_BITS-1:0]              cum_s2 [NN];
	logic [pwws_pkg::FRAC_BITS-1:0]   rnd_s2;
	logic [pwws_pkg::COL_BITS-1:0]    col_s2;
	logic [pwws_pkg::COUNT_BITS-1:0]  cnt_s2;

	always_ff @(posedge clk) begin
		if (load_s2) begin
			act_s2  <= act_s1;
			cand_s2 <= cand;
			cum_s2  <= cum;
			rnd_s2  <= rnd_s1;
			col_s2  <= col_s1;
			cnt_s2  <= clus_cnt;
		end
	end

	// ---------------- stage 3: roulette pick and walker update ----------------
	logic [LHS_BITS-1:0]  lhs;
	logic [SUM_BITS-1:0]  lhs_hi;
	logic [NN-1:0]        hit;
	pwws_pkg::dir_t       pick, last, dir_sel;

	// r*S < C*65536 is the same as floor(r*S / 65536) < C
	assign lhs    = LHS_BITS'(rnd_s2) * LHS_BITS'(cum_s2[NN-1]);
	assign lhs_hi = lhs[LHS_BITS-1:pwws_pkg::FRAC_BITS];

	always_comb begin
		pick = pwws_pkg::DIR_STAY;
		last = pwws_pkg::DIR_STAY;
		for (int i = 0; i < NN; i++) begin
			hit[i] = cand_s2[i] && (lhs_hi < cum_s2[i]);
			if (cand_s2[i])
				last = pwws_pkg::DIR_BITS'(i);
		end
		// lowest hit wins
		for (int i = NN - 1; i >= 0; i--)
			if (hit[i])
				pick = pwws_pkg::DIR_BITS'(i);
		// zero weight sum never hits: fall back to the last candidate
		dir_sel = (|hit) ? pick : last;
	end

	logic [COORD_BITS-1:0] walker_x_q, walker_y_q;
	logic                  walker_done_q;
	logic [COORD_BITS-1:0] x_n, y_n;
	logic                  done_n, joined_n;
	pwws_pkg::dir_t        dir_n;
	logic [31:0]           y_ext, bottom_row;
	logic                  at_bottom;

	always_comb begin
		x_n      = walker_x_q;
		y_n      = walker_y_q;
		done_n   = walker_done_q;
		joined_n = 1'b0;
		dir_n    = pwws_pkg::DIR_STAY;
		case (act_s2)
			pwws_pkg::ACT_START: begin
				x_n    = COORD_BITS'(col_s2);
				y_n    = COORD_BITS'(1);
				done_n = 1'b0;
			end
			pwws_pkg::ACT_MOVE: begin
				if (!walker_done_q && (|cand_s2)) begin
					dir_n = dir_sel;
					x_n   = walker_x_q + COORD_BITS'(pwws_pkg::dir_col(dir_sel)) -
					        COORD_BITS'(1);
					y_n   = walker_y_q + COORD_BITS'(pwws_pkg::dir_row(dir_sel)) -
					        COORD_BITS'(1);
				end
			end
			pwws_pkg::ACT_SETTLE: begin
				if (cnt_s2 >= threshold_q) begin
					joined_n = 1'b1;
					done_n   = 1'b1;
				end
			end
			default: ;
		endcase
		y_ext      = 32'(y_n);
		bottom_row = 32'(height_q) - 32'd2;
		at_bottom  = (height_q >= 16'd2) && (y_ext == bottom_row);
		// bottom check runs after every move on a live walker, also when it stays
		if (act_s2 == pwws_pkg::ACT_MOVE && !walker_done_q && at_bottom)
			done_n = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walker_x_q    <= '0;
			walker_y_q    <= '0;
			walker_done_q <= 1'b0;
		end else if (load_out) begin
			walker_x_q    <= x_n;
			walker_y_q    <= y_n;
			walker_done_q <= done_n;
		end
	end

	// ---------------- result register ----------------
	logic [pwws_pkg::M_TDATA_BITS-1:0] out_q;

	always_ff @(posedge clk) begin
		if (load_out)
			out_q <= {2'b00, done_n, joined_n, dir_n,
			          pwws_pkg::OUT_COORD_BITS'(y_n),
			          pwws_pkg::OUT_COORD_BITS'(x_n)};
	end

	assign m_tdata = out_q;

endmodule

// ===== hw/rtl/pwws_checker.sv =====
module pwws_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [pwws_pkg::M_TDATA_BITS-1:0] m_tdata
);

	logic [2:0] in_flight_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_flight_q <= '0;
		else if (in_acc && !out_acc)
			in_flight_q <= in_flight_q + 3'd1;
		else if (out_acc && !in_acc)
			in_flight_q <= in_flight_q - 3'd1;
	end

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// no more requests in flight than pipeline stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q <= 3'd3)
		else $error("too many requests in flight");

	// raise no result that was never requested
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> in_flight_q != 3'd0)
		else $error("result without a request");

	// a join finishes the walker and never moves it
	a_join: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[36] |->
		m_tdata[37] && (m_tdata[35:32] == pwws_pkg::DIR_STAY))
		else $error("join result inconsistent");

endmodule

bind potential_weighted_walk_step_unit pwws_checker u_pwws_checker (.*);

// ===== tb/walk_step_checker.sv =====
module walk_step_checker
	import pwws_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [S_TDATA_BITS-1:0]  s_tdata,
	input  logic [ACTION_BITS-1:0]   s_tuser,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [M_TDATA_BITS-1:0]  m_tdata,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	input  logic [APB_DATA_BITS-1:0] prdata,
	input  logic                     pready,
	output int                       fail_count,
	output int                       results_checked,
	output int                       outstanding
);

	// packed in m_tdata order, last member in the lowest bits
	typedef struct packed {
		logic                      finished;
		logic                      joined;
		dir_t                      dir;
		logic [OUT_COORD_BITS-1:0] y;
		logic [OUT_COORD_BITS-1:0] x;
	} walk_result_t;

	walk_result_t due_results[$];

	logic [OUT_COORD_BITS-1:0] walker_x, walker_y;
	logic                      walker_done;
	logic [THR_BITS-1:0]       join_threshold;
	logic [HEIGHT_BITS-1:0]    field_rows;

	initial begin
		fail_count = 0;
		results_checked = 0;
	end

	task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
	endtask

	// one walker step; updates the walker copy and returns what the block should report
	function automatic walk_result_t advance_walker(input action_t act,
			input logic [ROW_BITS-1:0] top_row, input logic [ROW_BITS-1:0] mid_row,
			input logic [ROW_BITS-1:0] bot_row, input logic [CLASS_BITS-1:0] classes,
			input logic [FRAC_BITS-1:0] frac, input logic [COL_BITS-1:0] column);
		logic [ROW_BITS-1:0] rows [3];
		logic [15:0]         centre, pot;
		logic [63:0]         weight [9];
		logic [63:0]         total, running, lhs;
		bit                  free_cell [9];
		int                  last, clusters;
		dir_t                pick;
		logic                joined;
		walk_result_t        r;
		rows[0] = top_row;
		rows[1] = mid_row;
		rows[2] = bot_row;
		pick = DIR_STAY;
		joined = 1'b0;
		case (act)
			ACT_START: begin
				walker_x = column;
				walker_y = 16'd1;
				walker_done = 1'b0;
			end
			ACT_MOVE: begin
				if (!walker_done) begin
					centre = mid_row[31:16];
					total = '0;
					last = -1;
					for (int k = 0; k < NUM_NEIGH; k++) begin
						free_cell[k] = (k != CENTRE_IDX) && (classes[2*k +: 2] == CLS_EMPTY);
						weight[k] = '0;
						if (free_cell[k]) begin
							pot = rows[k/3][16*(k%3) +: 16];
							weight[k] = (pot >= centre) ? 64'(pot - centre) : 64'(centre - pot);
							total += weight[k];
							last = k;
						end
					end
					// roulette: take the first candidate with frac*sum < cumulative*2^16
					if (last >= 0) begin
						lhs = 64'(frac) * total;
						pick = dir_t'(last);
						running = '0;
						for (int k = 0; k < NUM_NEIGH; k++) begin
							if (free_cell[k]) begin
								running += weight[k];
								if (lhs < (running << 16)) begin
									pick = dir_t'(k);
									break;
								end
							end
						end
						walker_x = 16'(int'(walker_x) + int'(pick) % 3 - 1);
						walker_y = 16'(int'(walker_y) + int'(pick) / 3 - 1);
					end
					if (int'(walker_y) == int'(field_rows) - 2)
						walker_done = 1'b1;
				end
			end
			ACT_SETTLE: begin
				clusters = 0;
				for (int k = 0; k < NUM_NEIGH; k++)
					if (classes[2*k +: 2] == CLS_CLUSTER)
						clusters++;
				if (clusters >= int'(join_threshold)) begin
					joined = 1'b1;
					walker_done = 1'b1;
				end
			end
			default: ;
		endcase
		r.x = walker_x;
		r.y = walker_y;
		r.dir = pick;
		r.joined = joined;
		r.finished = walker_done;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		walk_result_t             want, got;
		logic [APB_DATA_BITS-1:0] readback;
		if (!arst_n) begin
			walker_x = '0;
			walker_y = '0;
			walker_done = 1'b0;
			join_threshold = THRESHOLD_RST;
			field_rows = HEIGHT_RST;
			due_results.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_THRESHOLD)
						join_threshold = pwdata[THR_BITS-1:0];
					else
						field_rows = pwdata[HEIGHT_BITS-1:0];
				end else begin
					readback = (paddr[2] == REG_THRESHOLD) ?
						APB_DATA_BITS'(join_threshold) : APB_DATA_BITS'(field_rows);
					if (prdata !== readback)
						flag("register readback", readback, prdata);
				end
			end
			// retire before predicting: a result never belongs to a request taken at the same edge
			if (m_tvalid && m_tready) begin
				got = walk_result_t'(m_tdata[$bits(walk_result_t)-1:0]);
				if (due_results.size() == 0) begin
					flag("result with nothing expected", '0, m_tdata);
				end else begin
					want = due_results.pop_front();
					results_checked <= results_checked + 1;
					if (got.x !== want.x)
						flag("pos_x", want.x, got.x);
					if (got.y !== want.y)
						flag("pos_y", want.y, got.y);
					if (got.dir !== want.dir)
						flag("direction", want.dir, got.dir);
					if (got.joined !== want.joined)
						flag("joined", want.joined, got.joined);
					if (got.finished !== want.finished)
						flag("finished", want.finished, got.finished);
				end
			end
			if (s_tvalid && s_tready)
				due_results.insert(due_results.size(), advance_walker(action_t'(s_tuser),
					s_tdata[47:0], s_tdata[95:48], s_tdata[143:96], s_tdata[161:144],
					s_tdata[177:162], s_tdata[193:178]));
			outstanding <= due_results.size();
		end
	end

endmodule

// ===== tb/potential_weighted_walk_step_unit_tb.sv =====
module potential_weighted_walk_step_unit_tb;
	import pwws_pkg::*;

	// class codes and action beyond the ones the package names
	localparam class_t  CLS_OTHER    = 2'd2;
	localparam class_t  CLS_RESERVED = 2'd3;
	localparam action_t ACT_UNUSED   = 2'd3;

	localparam logic [APB_ADDR_BITS-1:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};
	localparam logic [APB_ADDR_BITS-1:0] ADDR_HEIGHT    = {REG_HEIGHT, 2'b00};

	// potential patterns for move requests
	localparam int POT_RANDOM = 0;
	localparam int POT_TINY   = 1;
	localparam int POT_FLAT   = 2;
	localparam int POT_RAIL   = 3;

	localparam int CYCLE_LIMIT      = 100000;
	localparam int HOLD_CYCLES      = 64;
	localparam int TAIL_CYCLES      = 6;
	localparam int RANDOM_PER_PHASE = 55;
	localparam int NUM_PHASES       = 7;

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	// [47:0] potentials_top, [95:48] potentials_middle, [143:96] potentials_bottom,
	// [161:144] cell_classes, [177:162] random_fraction, [193:178] start_column
	logic [S_TDATA_BITS-1:0]  s_tdata;
	// [1:0] action
	logic [ACTION_BITS-1:0]   s_tuser;
	logic                     m_tvalid;
	logic                     m_tready;
	// [15:0] pos_x, [31:16] pos_y, [35:32] direction, [36] joined, [37] finished
	logic [M_TDATA_BITS-1:0]  m_tdata;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	int fail_count, results_checked, outstanding;
	int cycle_count = 0;
	int starts = 0, moves = 0, settles = 0, unused_sent = 0, settings = 0;

	// quiet: neither side idles; hold_request: receiver holds off once for a long stretch
	bit quiet = 1'b0;
	bit hold_request = 1'b0;

	int thr_plan [NUM_PHASES]    = '{1, 9, 5, 2, 7, 1, 3};
	int height_plan [NUM_PHASES] = '{65535, 4, 12, 6, 256, 3, 8};

	potential_weighted_walk_step_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	walk_step_checker walk_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.fail_count(fail_count), .results_checked(results_checked),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: end the run if the block stops making progress
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
			$display("FAIL potential_weighted_walk_step_unit");
			$finish;
		end
	end

	// receiver: draw a stall per result, or take one long hold-off when asked
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				stall = HOLD_CYCLES;
			end else begin
				stall = quiet ? 0 : $urandom_range(0, 6);
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	function automatic logic [ROW_BITS-1:0] noise48();
		return ROW_BITS'({$urandom(), $urandom()});
	endfunction

	// spawn columns lean toward both edges so moves wrap the column
	function automatic logic [COL_BITS-1:0] spawn_column();
		case ($urandom_range(0, 3))
			0:       return COL_BITS'($urandom_range(1, 3));
			1:       return COL_BITS'($urandom_range(65532, 65534));
			default: return COL_BITS'($urandom_range(1, 65534));
		endcase
	endfunction

	// every neighbor blocked except one
	function automatic logic [CLASS_BITS-1:0] only_free(input int idx);
		logic [CLASS_BITS-1:0] c;
		c = {NUM_NEIGH{CLS_OTHER}};
		c[2*idx +: 2] = CLS_EMPTY;
		return c;
	endfunction

	// the first n cells in index order are cluster, the rest empty
	function automatic logic [CLASS_BITS-1:0] cluster_cells(input int n);
		logic [CLASS_BITS-1:0] c;
		for (int k = 0; k < NUM_NEIGH; k++)
			c[2*k +: 2] = (k < n) ? CLS_CLUSTER : CLS_EMPTY;
		return c;
	endfunction

	// mostly free neighborhoods, now and then a fully boxed-in walker
	function automatic logic [CLASS_BITS-1:0] move_classes();
		logic [CLASS_BITS-1:0] c;
		int                    roll;
		if ($urandom_range(0, 9) == 0)
			return {NUM_NEIGH{class_t'($urandom_range(1, 3))}};
		for (int k = 0; k < NUM_NEIGH; k++) begin
			roll = $urandom_range(0, 9);
			if (roll < 6)
				c[2*k +: 2] = CLS_EMPTY;
			else if (roll < 8)
				c[2*k +: 2] = CLS_CLUSTER;
			else if (roll == 8)
				c[2*k +: 2] = CLS_OTHER;
			else
				c[2*k +: 2] = CLS_RESERVED;
		end
		return c;
	endfunction

	// per-request cluster density so the count sweeps 0..9
	function automatic logic [CLASS_BITS-1:0] settle_classes();
		logic [CLASS_BITS-1:0] c;
		int                    density;
		density = $urandom_range(0, 10);
		for (int k = 0; k < NUM_NEIGH; k++) begin
			if ($urandom_range(0, 9) < density)
				c[2*k +: 2] = CLS_CLUSTER;
			else
				case ($urandom_range(0, 2))
					0:       c[2*k +: 2] = CLS_EMPTY;
					1:       c[2*k +: 2] = CLS_OTHER;
					default: c[2*k +: 2] = CLS_RESERVED;
				endcase
		end
		return c;
	endfunction

	// offer one request; valid stays up when the next one follows with no gap
	task automatic offer(input action_t act, input logic [ROW_BITS-1:0] top_row,
			input logic [ROW_BITS-1:0] mid_row, input logic [ROW_BITS-1:0] bot_row,
			input logic [CLASS_BITS-1:0] cls, input logic [FRAC_BITS-1:0] frac,
			input logic [COL_BITS-1:0] col);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {6'b0, col, frac, cls, bot_row, mid_row, top_row};
		do @(posedge clk); while (!s_tready);
		case (act)
			ACT_START:  starts++;
			ACT_MOVE:   moves++;
			ACT_SETTLE: settles++;
			default:    unused_sent++;
		endcase
	endtask

	task automatic offer_move(input logic [CLASS_BITS-1:0] cls);
		logic [ROW_BITS-1:0]  r [3];
		logic [15:0]          level;
		logic [FRAC_BITS-1:0] frac;
		int                   mode;
		mode = $urandom_range(POT_RANDOM, POT_RAIL);
		level = 16'($urandom());
		for (int i = 0; i < 3; i++)
			case (mode)
				POT_RANDOM: r[i] = noise48();
				POT_TINY:   r[i] = {16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
					16'($urandom_range(0, 3))};
				POT_FLAT:   r[i] = {3{level}};
				default:    r[i] = {($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000,
					($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000,
					($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000};
			endcase
		case ($urandom_range(0, 5))
			0:       frac = '0;
			1:       frac = '1;
			default: frac = FRAC_BITS'($urandom());
		endcase
		offer(ACT_MOVE, r[0], r[1], r[2], cls, frac, spawn_column());
	endtask

	// drop valid, wait for every due result, then let the pipeline settle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [APB_ADDR_BITS-1:0] addr,
			input logic [APB_DATA_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// write both registers and read them back; the checker compares readback
	task automatic program_walk(input int threshold, input int height);
		apb_access(1'b1, ADDR_THRESHOLD, APB_DATA_BITS'(threshold));
		apb_access(1'b1, ADDR_HEIGHT, APB_DATA_BITS'(height));
		apb_access(1'b0, ADDR_THRESHOLD, '0);
		apb_access(1'b0, ADDR_HEIGHT, '0);
		settings++;
	endtask

	// walks: a start, then a run of moves with the odd settle check, unused action or start mixed in
	task automatic run_walks(input int count);
		int sent, steps, roll;
		sent = 0;
		while (sent < count) begin
			offer(ACT_START, noise48(), noise48(), noise48(), CLASS_BITS'($urandom()),
				FRAC_BITS'($urandom()), spawn_column());
			sent++;
			steps = $urandom_range(2, 14);
			repeat (steps) begin
				roll = $urandom_range(0, 99);
				if (roll < 80)
					offer_move(move_classes());
				else if (roll < 93)
					offer(ACT_SETTLE, noise48(), noise48(), noise48(), settle_classes(),
						FRAC_BITS'($urandom()), spawn_column());
				else if (roll < 97)
					offer(ACT_UNUSED, noise48(), noise48(), noise48(),
						CLASS_BITS'($urandom()), FRAC_BITS'($urandom()), spawn_column());
				else
					offer(ACT_START, noise48(), noise48(), noise48(),
						CLASS_BITS'($urandom()), FRAC_BITS'($urandom()), spawn_column());
				sent++;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= ACT_START;
		s_tdata <= '0;
		m_tready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: threshold 1, height 256
		// settle on an empty window, then a move straight from the reset position
		offer(ACT_SETTLE, '0, '0, '0, cluster_cells(0), '0, 16'd1);
		offer(ACT_MOVE, noise48(), noise48(), noise48(), only_free(0), 16'h1234, 16'd1);
		offer(ACT_START, '0, '0, '0, '0, '0, 16'd1);
		// boxed in by every non-empty code: stay
		offer(ACT_MOVE, noise48(), noise48(), noise48(), {NUM_NEIGH{CLS_RESERVED}}, '1, 16'd1);
		offer(ACT_MOVE, noise48(), noise48(), noise48(),
			{3{CLS_RESERVED, CLS_OTHER, CLS_CLUSTER}}, '0, 16'd1);
		// flat field: zero weight sum falls to the last candidate
		offer(ACT_MOVE, '0, '0, '0, cluster_cells(0), 16'h8000, 16'd1);
		// steepest weights with the fraction at both ends
		offer(ACT_MOVE, '1, {16'hFFFF, 16'h0000, 16'hFFFF}, '1, cluster_cells(0), '0, 16'd1);
		offer(ACT_MOVE, '1, {16'hFFFF, 16'h0000, 16'hFFFF}, '1, cluster_cells(0), '1, 16'd1);
		offer(ACT_MOVE, '0, {16'h0000, 16'hFFFF, 16'h0000}, '0, cluster_cells(0), 16'h8000,
			16'd1);
		offer(ACT_MOVE, noise48(), noise48(), noise48(), only_free(3), 16'h4000, 16'd1);
		// wrap the column past the top and the row past zero
		offer(ACT_START, '0, '0, '0, '0, '0, 16'd65534);
		offer(ACT_MOVE, noise48(), noise48(), noise48(), only_free(5), '1, 16'd1);
		offer(ACT_MOVE, noise48(), noise48(), noise48(), only_free(5), '0, 16'd1);
		offer(ACT_MOVE, noise48(), noise48(), noise48(), only_free(1), '1, 16'd1);
		offer(ACT_MOVE, noise48(), noise48(), noise48(), only_free(1), '0, 16'd1);
		// cluster only in the centre still counts; then a move after finish is ignored
		offer(ACT_SETTLE, '0, '0, '0, CLASS_BITS'(CLS_CLUSTER) << (2 * CENTRE_IDX), '0, 16'd1);
		offer(ACT_MOVE, noise48(), noise48(), noise48(), cluster_cells(0), 16'h2222, 16'd1);
		offer(ACT_SETTLE, '0, '0, '0, cluster_cells(0), '0, 16'd1);
		offer(ACT_UNUSED, noise48(), noise48(), noise48(), '1, '1, 16'hFFFF);
		offer(ACT_START, '1, '1, '1, '1, '1, 16'hAAAA);
		drain_results();

		// threshold 9, field of 3 rows: a stay on row 1 reaches the bottom row
		program_walk(9, 3);
		offer(ACT_START, '0, '0, '0, '0, '0, 16'h5555);
		offer(ACT_MOVE, noise48(), noise48(), noise48(), {NUM_NEIGH{CLS_OTHER}}, '0, 16'd1);
		offer(ACT_START, '0, '0, '0, '0, '0, 16'd100);
		offer(ACT_SETTLE, '0, '0, '0, cluster_cells(8), '0, 16'd1);
		offer(ACT_SETTLE, '0, '0, '0, cluster_cells(9), '0, 16'd1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			program_walk(thr_plan[p], height_plan[p]);
			// phase 2 back-pressures the block hard; phase 4 runs with no idling
			quiet = (p == 2) || (p == 4);
			if (p == 2)
				hold_request = 1'b1;
			run_walks(RANDOM_PER_PHASE);
			quiet = 1'b0;
		end
		drain_results();

		$display("walked %0d starts, %0d moves, %0d settle checks, %0d unused-action requests",
			starts, moves, settles, unused_sent);
		$display("across %0d register settings; %0d results compared, %0d mismatches",
			settings, results_checked, fail_count);
		if (fail_count == 0)
			$display("PASS potential_weighted_walk_step_unit");
		else
			$display("FAIL potential_weighted_walk_step_unit");
		$finish;
	end

endmodule
